>>> design/csl_pkg.sv
// shared types and constants for the calibration sweep linear fit block
// no dependencies; imported by csl_mul, csl_div and the top level
`default_nettype none
package csl_pkg;

    // arithmetic widths of the serial units
    localparam int ACC_W  = 64;
    localparam int PROD_W = 96;
    localparam int CNT_W  = $clog2(PROD_W);

    // micrometres per volt in Q16.8 times the millivolt scale
    localparam logic [ACC_W-1:0] SCALE_K = 64'd256000;

    // request codes
    typedef enum logic [2:0] {
        REQ_COMMIT = 3'd0,
        REQ_SET    = 3'd1,
        REQ_INC    = 3'd2,
        REQ_DEC    = 3'd3,
        REQ_HALT   = 3'd4
    } t_req;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_START_LOC    = 2'd1,
        CFG_END_LOC      = 2'd2,
        CFG_LOC_STEP     = 2'd3
    } t_cfg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_XX,
        S_XY,
        S_ND,
        S_SX2,
        S_NXY,
        S_SXY,
        S_EMUL,
        S_EDIV,
        S_LOC,
        S_VMUL,
        S_VDIV,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

>>> design/csl_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on csl_pkg; stops as soon as the remaining multiplier bits are zero
`default_nettype none
module csl_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [csl_pkg::ACC_W-1:0]   i_a,
    input  wire logic [csl_pkg::ACC_W-1:0]   i_b,
    output logic                             o_done,
    output logic [csl_pkg::PROD_W-1:0]       o_prod
);
    import csl_pkg::*;

    logic              r_busy;
    logic [PROD_W-1:0] r_a;
    logic [ACC_W-1:0]  r_b;
    logic [PROD_W-1:0] r_acc;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_b == '0) begin
            r_busy <= 1'b0;
        end
    end

    // shift-add datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= PROD_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_busy && (r_b == '0);
    assign o_prod = r_acc;
endmodule
`default_nettype wire

>>> design/csl_div.sv
// restoring divider, one quotient bit per cycle, quotient magnitude capped
// depends on csl_pkg; result is capped at 2**(QW-1)
`default_nettype none
module csl_div #(
    parameter int QW = 24
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [csl_pkg::PROD_W-1:0]  i_dividend,
    input  wire logic [csl_pkg::ACC_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [QW-1:0]                    o_mag
);
    import csl_pkg::*;

    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(PROD_W - 1);
    localparam logic [CNT_W-1:0] Q_TOP   = CNT_W'(QW - 1);

    logic              r_busy;
    logic              r_fin;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_dvd;
    logic [ACC_W-1:0]  r_dvs;
    logic [ACC_W-1:0]  r_rem;
    logic [QW-2:0]     r_q;
    logic              r_big;
    logic [ACC_W:0]    w_rem_sh;
    logic [ACC_W:0]    w_diff;
    logic              w_ge;

    // trial subtract
    always_comb begin
        w_rem_sh = {r_rem, r_dvd[PROD_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_dvs};
        w_ge     = !w_diff[ACC_W];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_TOP;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= r_dvd << 1;
            r_rem <= w_ge ? w_diff[ACC_W-1:0] : w_rem_sh[ACC_W-1:0];
            r_q   <= {r_q[QW-3:0], w_ge};
            if (w_ge && r_cnt >= Q_TOP) begin
                r_big <= 1'b1;
            end
        end
    end

    assign o_done = r_fin;
    assign o_mag  = r_big ? {1'b1, {(QW-1){1'b0}}} : {1'b0, r_q};
endmodule
`default_nettype wire

>>> design/calibration_sweep_linear_fit.sv
// top level of the calibration sweep linear fit block
// depends on csl_pkg, csl_mul and csl_div
// One request at a time. Set, increment, decrement, halt and ignored requests go
// straight to the finish state; a commit runs on the shared bit-serial multiplier
// (one multiplier bit per cycle, up to seven products per commit plus two scalings)
// and the 96-step restoring divider used once for the scale and once for the
// voltage. The result sits in an output register, so the next request can be
// taken while it waits. Configuration writes are taken at any time but must be made
// while idle.
`default_nettype none
module calibration_sweep_linear_fit #(
    parameter int MAX_POINTS  = 64,
    parameter int VALUE_WIDTH = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [2:0]              i_req_type,
    input  wire logic [VALUE_WIDTH-1:0]  i_voltage_arg,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic                         o_recognized,
    output logic [VALUE_WIDTH-1:0]       o_focus_location,
    output logic [VALUE_WIDTH-1:0]       o_mirror_voltage,
    output logic [5:0]                   o_step_index,
    output logic [VALUE_WIDTH-1:0]       o_scale_estimate,
    output logic                         o_fit_valid,
    output logic                         o_sweep_done,
    output logic                         o_halted,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [VALUE_WIDTH-1:0]  i_cfg_data
);
    import csl_pkg::*;

    localparam int VW      = VALUE_WIDTH;
    localparam int LIM_CAP = (MAX_POINTS > 127) ? 127 : MAX_POINTS;
    localparam logic [6:0] LIM_HI = 7'(LIM_CAP);
    localparam logic signed [ACC_W-1:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] VMIN = -VMAX - 64'sd1;

    // saturate a 64-bit signed value to the value width
    function automatic logic [VW-1:0] sat64(input logic signed [ACC_W-1:0] v);
        logic [VW-1:0] res;
        if (v > VMAX) begin
            res = VMAX[VW-1:0];
        end else if (v < VMIN) begin
            res = VMIN[VW-1:0];
        end else begin
            res = v[VW-1:0];
        end
        return res;
    endfunction

    // sign extend a value to 64 bits
    function automatic logic signed [ACC_W-1:0] sx(input logic [VW-1:0] v);
        return ACC_W'(signed'(v));
    endfunction

    // 64-bit magnitude
    function automatic logic [ACC_W-1:0] mag64(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + 1'b1) : v;
    endfunction

    // apply sign to a capped quotient magnitude, saturating the positive end
    function automatic logic [VW-1:0] signed_q(input logic [VW-1:0] m, input logic neg);
        logic [VW-1:0] res;
        if (neg) begin
            res = ~m + 1'b1;
        end else if (m[VW-1]) begin
            res = {1'b0, {(VW-1){1'b1}}};
        end else begin
            res = m;
        end
        return res;
    endfunction

    // configuration
    logic [6:0]    r_sample_count;
    logic [VW-1:0] r_end_loc;
    logic [VW-1:0] r_loc_step;

    // sweep state
    logic [VW-1:0]    r_voltage;
    logic [VW-1:0]    r_location;
    logic [6:0]       r_step;
    logic [6:0]       r_count;
    logic [ACC_W-1:0] r_sum_x;
    logic [ACC_W-1:0] r_sum_y;
    logic [ACC_W-1:0] r_sum_xx;
    logic [ACC_W-1:0] r_sum_xy;
    logic             r_done;
    logic             r_halt;
    logic [VW-1:0]    r_scale;
    logic             r_valid;
    logic             r_rec;

    // fit scratch
    logic [ACC_W-1:0]  r_t;
    logic [ACC_W-1:0]  r_den;
    logic [ACC_W-1:0]  r_num;
    logic [PROD_W-1:0] r_prod;

    // sequencer
    t_state r_state, n_state;
    logic   r_launch;

    // output register
    logic          r_out_valid;
    logic          r_o_rec;
    logic [VW-1:0] r_o_loc;
    logic [VW-1:0] r_o_volt;
    logic [5:0]    r_o_step;
    logic [VW-1:0] r_o_scale;
    logic          r_o_fit;
    logic          r_o_done;
    logic          r_o_halt;

    // unit connections
    logic              mul_start, mul_done;
    logic [ACC_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_prod;
    logic              div_start, div_done;
    logic [ACC_W-1:0]  div_dvs;
    logic [VW-1:0]     div_mag;

    // derived conditions
    logic                    in_acc;
    logic                    live;
    logic                    slot_free;
    logic [6:0]              lim_m1;
    t_state                  w_post;
    logic [ACC_W-1:0]        w_sub;
    logic signed [ACC_W-1:0] w_diff;
    logic [VW-1:0]           w_tmp;
    logic signed [ACC_W-1:0] w_ten_scale;
    logic                    w_vcond;

    csl_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    csl_div #(.QW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_mag      (div_mag)
    );

    // handshake and sweep conditions
    always_comb begin
        in_acc    = i_in_valid && !o_in_stall;
        live      = !r_done && !r_halt && (i_req_type <= REQ_HALT);
        slot_free = !r_out_valid || !i_out_stall;
        if (r_sample_count < 7'd2) begin
            lim_m1 = 7'd1;
        end else if (r_sample_count > LIM_HI) begin
            lim_m1 = LIM_HI - 7'd1;
        end else begin
            lim_m1 = r_sample_count - 7'd1;
        end
        w_post      = (r_step < lim_m1) ? S_LOC : S_FIN;
        w_sub       = r_t - mul_prod[ACC_W-1:0];
        w_diff      = sx(r_end_loc) - signed'(mul_prod[ACC_W-1:0]);
        w_tmp       = sat64(w_diff);
        w_ten_scale = (sx(r_scale) <<< 3) + (sx(r_scale) <<< 1);
        w_vcond     = (r_scale != '0) && (w_ten_scale > sx(w_tmp));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) begin
                n_state = (live && i_req_type == REQ_COMMIT) ? S_XX : S_FIN;
            end
            S_XX:   if (mul_done) n_state = S_XY;
            S_XY:   if (mul_done) n_state = (r_count < 7'd2) ? w_post : S_ND;
            S_ND:   if (mul_done) n_state = S_SX2;
            S_SX2:  if (mul_done) n_state = S_NXY;
            S_NXY:  if (mul_done) n_state = S_SXY;
            S_SXY:  if (mul_done) begin
                n_state = (w_sub == '0 || r_den == '0) ? w_post : S_EMUL;
            end
            S_EMUL: if (mul_done) n_state = S_EDIV;
            S_EDIV: if (div_done) n_state = w_post;
            S_LOC:  if (mul_done) n_state = w_vcond ? S_VMUL : S_FIN;
            S_VMUL: if (mul_done) n_state = S_VDIV;
            S_VDIV: if (div_done) n_state = S_FIN;
            S_FIN:  if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // unit operands and launches
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_dvs   = mag64(r_num);
        mul_start = 1'b0;
        div_start = 1'b0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_XX: begin
                mul_a = sx(r_location);
                mul_b = sx(r_location);
            end
            S_XY: begin
                mul_a = sx(r_location);
                mul_b = sx(r_voltage);
            end
            S_ND: begin
                mul_a = r_sum_xx;
                mul_b = ACC_W'(r_count);
            end
            S_SX2: begin
                mul_a = r_sum_x;
                mul_b = r_sum_x;
            end
            S_NXY: begin
                mul_a = r_sum_xy;
                mul_b = ACC_W'(r_count);
            end
            S_SXY: begin
                mul_a = r_sum_x;
                mul_b = r_sum_y;
            end
            S_EMUL: begin
                mul_a = mag64(r_den);
                mul_b = SCALE_K;
            end
            S_LOC: begin
                mul_a = sx(r_loc_step);
                mul_b = ACC_W'(r_step);
            end
            S_VMUL: begin
                mul_a = mag64(sx(r_location));
                mul_b = SCALE_K;
            end
            S_VDIV: begin
                div_dvs = mag64(sx(r_scale));
            end
            default: begin
                mul_a = '0;
            end
        endcase
        if (r_launch) begin
            if (r_state == S_EDIV || r_state == S_VDIV) begin
                div_start = 1'b1;
            end else if (r_state != S_IDLE && r_state != S_FIN) begin
                mul_start = 1'b1;
            end
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= (n_state != r_state);
        end
    end

    // sweep state, fit sums and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= 7'd10;
            r_end_loc      <= '0;
            r_loc_step     <= '0;
            r_voltage      <= '0;
            r_location     <= '0;
            r_step         <= '0;
            r_count        <= '0;
            r_sum_x        <= '0;
            r_sum_y        <= '0;
            r_sum_xx       <= '0;
            r_sum_xy       <= '0;
            r_done         <= 1'b0;
            r_halt         <= 1'b0;
            r_scale        <= '0;
            r_valid        <= 1'b0;
            r_rec          <= 1'b0;
        end else begin
            // request decode
            if (r_state == S_IDLE && in_acc) begin
                r_rec <= live;
                if (live) begin
                    case (i_req_type)
                        REQ_COMMIT: begin
                            r_sum_x <= r_sum_x + sx(r_location);
                            r_sum_y <= r_sum_y + sx(r_voltage);
                            r_count <= r_count + 7'd1;
                        end
                        REQ_SET:  r_voltage <= i_voltage_arg;
                        REQ_INC:  r_voltage <= sat64(sx(r_voltage) + sx(i_voltage_arg));
                        REQ_DEC:  r_voltage <= sat64(sx(r_voltage) - sx(i_voltage_arg));
                        REQ_HALT: r_halt <= 1'b1;
                        default:  r_halt <= r_halt;
                    endcase
                end
            end

            // commit sequence
            case (r_state)
                S_XX: if (mul_done) r_sum_xx <= r_sum_xx + mul_prod[ACC_W-1:0];
                S_XY: if (mul_done) begin
                    r_sum_xy <= r_sum_xy + mul_prod[ACC_W-1:0];
                    if (r_count < 7'd2) begin
                        r_scale <= '0;
                        r_valid <= 1'b0;
                    end
                end
                S_ND:  if (mul_done) r_t <= mul_prod[ACC_W-1:0];
                S_SX2: if (mul_done) r_den <= w_sub;
                S_NXY: if (mul_done) r_t <= mul_prod[ACC_W-1:0];
                S_SXY: if (mul_done) begin
                    r_num <= w_sub;
                    if (w_sub == '0 || r_den == '0) begin
                        r_scale <= '0;
                        r_valid <= 1'b0;
                    end else begin
                        r_valid <= 1'b1;
                    end
                end
                S_EMUL: if (mul_done) r_prod <= mul_prod;
                S_EDIV: if (div_done) begin
                    r_scale <= signed_q(div_mag, r_den[ACC_W-1] ^ r_num[ACC_W-1]);
                end
                S_LOC: if (mul_done) begin
                    r_location <= w_tmp;
                    r_step     <= r_step + 7'd1;
                    if (!w_vcond) begin
                        r_voltage <= '0;
                    end
                end
                S_VMUL: if (mul_done) r_prod <= mul_prod;
                S_VDIV: if (div_done) begin
                    r_voltage <= signed_q(div_mag, r_location[VW-1] ^ r_scale[VW-1]);
                end
                default: r_t <= r_t;
            endcase

            // last point taken
            if (n_state == S_FIN
                && (r_state == S_XY || r_state == S_SXY || r_state == S_EDIV)) begin
                r_done <= 1'b1;
            end

            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[6:0];
                    CFG_START_LOC: begin
                        if (r_count == '0 && !r_done && !r_halt) begin
                            r_location <= i_cfg_data;
                        end
                    end
                    CFG_END_LOC:  r_end_loc  <= i_cfg_data;
                    CFG_LOC_STEP: r_loc_step <= i_cfg_data;
                    default:      r_loc_step <= r_loc_step;
                endcase
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && slot_free) begin
            r_o_rec   <= r_rec;
            r_o_loc   <= r_location;
            r_o_volt  <= r_voltage;
            r_o_step  <= r_step[5:0];
            r_o_scale <= r_scale;
            r_o_fit   <= r_valid;
            r_o_done  <= r_done;
            r_o_halt  <= r_halt;
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_recognized     = r_o_rec;
    assign o_focus_location = r_o_loc;
    assign o_mirror_voltage = r_o_volt;
    assign o_step_index     = r_o_step;
    assign o_scale_estimate = r_o_scale;
    assign o_fit_valid      = r_o_fit;
    assign o_sweep_done     = r_o_done;
    assign o_halted         = r_o_halt;
endmodule
`default_nettype wire

>>> design/csl_checker.sv
// port-level checks for the calibration sweep linear fit block
// depends on calibration_sweep_linear_fit; bound to it below
`default_nettype none
module csl_checker #(
    parameter int VALUE_WIDTH = 24
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_stall,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_stall,
    input wire logic [VALUE_WIDTH-1:0] o_scale_estimate,
    input wire logic                   o_fit_valid,
    input wire logic                   o_sweep_done,
    input wire logic                   o_halted
);
    // one request at a time: an accepted request stalls the next
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    // result stays offered while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_scale_estimate) && $stable(o_fit_valid))
        else $error("stalled result changed");

    // no fit means zero scale
    a_fit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_fit_valid |-> o_scale_estimate == '0)
        else $error("scale without a valid fit");

    // a sweep never ends both by halt and by completion
    a_end_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_halted && o_sweep_done))
        else $error("halted and done together");
endmodule

bind calibration_sweep_linear_fit csl_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_csl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_scale_estimate (o_scale_estimate),
    .o_fit_valid      (o_fit_valid),
    .o_sweep_done     (o_sweep_done),
    .o_halted         (o_halted)
);
`default_nettype wire
